/* sv/mstsync_pkg.sv */
// Shared constants, types and codes for the timestamp synchronizer.
// No dependencies.
package mstsync_pkg;

   localparam int DEF_NUM_STREAMS = 4;
   localparam int DEF_BUF_DEPTH   = 16;
   localparam int DEF_TIME_BITS   = 32;

   localparam int SID_BITS     = 2;
   localparam int PAYLOAD_BITS = 32;
   localparam int ACTIVE_BITS  = 3;
   localparam int KIND_BITS    = 2;

   localparam logic [KIND_BITS-1:0] KIND_SYNC = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_LATE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DROP = 2'd2;

   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 3'd4;

   // Control into one stream buffer row
   typedef struct packed {
      logic ins;
      logic pop;
   } row_ctl_type;

   // Status out of one stream buffer row
   typedef struct packed {
      logic head_valid;
      logic full;
   } row_stat_type;

endpackage

/* sv/mstsync_cell.sv */
// One entry of a sorted stream buffer: holds, takes the new tuple, or shifts.
// Depends on mstsync_pkg.
module mstsync_cell import mstsync_pkg::*; #(
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  row_ctl_type             ctl,
   input  logic [TIME_BITS-1:0]    new_t,
   input  logic [PAYLOAD_BITS-1:0] new_p,
   input  logic                    left_keep,
   input  logic                    left_valid,
   input  logic [TIME_BITS-1:0]    left_t,
   input  logic [PAYLOAD_BITS-1:0] left_p,
   input  logic                    right_valid,
   input  logic [TIME_BITS-1:0]    right_t,
   input  logic [PAYLOAD_BITS-1:0] right_p,
   output logic                    keep,
   output logic                    valid,
   output logic [TIME_BITS-1:0]    time_q,
   output logic [PAYLOAD_BITS-1:0] pay_q
);

   logic                    valid_ff, valid_in;
   logic [TIME_BITS-1:0]    time_ff, time_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;

   // equal times stay ahead of the new tuple
   assign keep = valid_ff && (time_ff <= new_t);

   always_comb begin
      valid_in = valid_ff;
      time_in  = time_ff;
      pay_in   = pay_ff;
      if (ctl.ins) begin
         if (!keep) begin
            if (left_keep) begin
               valid_in = 1'b1;
               time_in  = new_t;
               pay_in   = new_p;
            end else begin
               valid_in = left_valid;
               time_in  = left_t;
               pay_in   = left_p;
            end
         end
      end else if (ctl.pop) begin
         valid_in = right_valid;
         time_in  = right_t;
         pay_in   = right_p;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      time_ff <= time_in;
      pay_ff  <= pay_in;
   end

   assign valid  = valid_ff;
   assign time_q = time_ff;
   assign pay_q  = pay_ff;

endmodule

/* sv/mstsync_row.sv */
// One stream's time-sorted buffer: a chain of cells plus a fill counter.
// Depends on mstsync_pkg and mstsync_cell.
module mstsync_row import mstsync_pkg::*; #(
   parameter int BUF_DEPTH = DEF_BUF_DEPTH,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  row_ctl_type             ctl,
   input  logic [TIME_BITS-1:0]    new_t,
   input  logic [PAYLOAD_BITS-1:0] new_p,
   output row_stat_type            stat,
   output logic [TIME_BITS-1:0]    head_t,
   output logic [PAYLOAD_BITS-1:0] head_p
);

   localparam int FILL_BITS = $clog2(BUF_DEPTH + 1);

   logic                    keep_w  [BUF_DEPTH];
   logic                    valid_w [BUF_DEPTH];
   logic [TIME_BITS-1:0]    time_w  [BUF_DEPTH];
   logic [PAYLOAD_BITS-1:0] pay_w   [BUF_DEPTH];

   logic [FILL_BITS-1:0] fill_ff, fill_in;

   for (genvar i = 0; i < BUF_DEPTH; i++) begin : g_cell
      logic                    lk, lv, rv;
      logic [TIME_BITS-1:0]    lt, rt;
      logic [PAYLOAD_BITS-1:0] lp, rp;
      if (i == 0) begin : g_first
         assign lk = 1'b1;
         assign lv = 1'b0;
         assign lt = '0;
         assign lp = '0;
      end else begin : g_mid
         assign lk = keep_w[i-1];
         assign lv = valid_w[i-1];
         assign lt = time_w[i-1];
         assign lp = pay_w[i-1];
      end
      if (i == BUF_DEPTH - 1) begin : g_last
         assign rv = 1'b0;
         assign rt = '0;
         assign rp = '0;
      end else begin : g_inner
         assign rv = valid_w[i+1];
         assign rt = time_w[i+1];
         assign rp = pay_w[i+1];
      end
      mstsync_cell #(.TIME_BITS(TIME_BITS)) u_cell (
         .clock(clock), .reset(reset), .ctl(ctl), .new_t(new_t), .new_p(new_p),
         .left_keep(lk), .left_valid(lv), .left_t(lt), .left_p(lp),
         .right_valid(rv), .right_t(rt), .right_p(rp),
         .keep(keep_w[i]), .valid(valid_w[i]), .time_q(time_w[i]), .pay_q(pay_w[i])
      );
   end

   always_comb begin
      fill_in = fill_ff;
      if (ctl.ins) begin
         fill_in = fill_ff + FILL_BITS'(1);
      end else if (ctl.pop) begin
         fill_in = fill_ff - FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign stat.head_valid = valid_w[0];
   assign stat.full       = (fill_ff == FILL_BITS'(BUF_DEPTH));
   assign head_t          = time_w[0];
   assign head_p          = pay_w[0];

endmodule

/* sv/multi_stream_timestamp_synchronizer.sv */
// Multi-stream timestamp synchronizer: top level, control sequencer and output register.
// Depends on mstsync_pkg and mstsync_row.
// Flow: a late or dropped tuple passes from the pending-result register to the output register.
// An insert writes its buffer, then each release round scans the stream heads and drains
// the released tuples stream by stream; the sequencer holds one transaction at a time, so the
// next is taken only once it is back in ST_IDLE.
// Reset (synchronous, active high) empties all buffers, clears sync time, sets
// active_streams to 4.
module multi_stream_timestamp_synchronizer import mstsync_pkg::*; #(
   parameter int NUM_STREAMS = DEF_NUM_STREAMS,
   parameter int BUF_DEPTH   = DEF_BUF_DEPTH,
   parameter int TIME_BITS   = DEF_TIME_BITS,
   localparam int DATA_RAW   = SID_BITS + TIME_BITS + PAYLOAD_BITS,
   localparam int DATA_BITS  = ((DATA_RAW + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // tdata: sid, event_time, payload (from bit 0 up), zero padded
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_BITS-1:0]   req_tdata,
   // tdata: out_sid, out_event_time, out_payload (from bit 0 up), zero padded
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_BITS-1:0]   rsp_tdata,
   // tuser: release_kind
   output logic [KIND_BITS-1:0]   rsp_tuser,
   // tlast: last_of_run
   output logic                   rsp_tlast,
   input  logic                   csr_wen,
   input  logic [ACTIVE_BITS-1:0] csr_wdata
);

   localparam int SW      = $clog2(NUM_STREAMS);
   localparam int CNT_BITS = $clog2(NUM_STREAMS + 1);

   // One-hot sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Unpack the request
   logic [SID_BITS-1:0]     in_sid;
   logic [TIME_BITS-1:0]    in_t;
   logic [PAYLOAD_BITS-1:0] in_p;
   logic [SW-1:0]           in_row;

   assign in_sid = req_tdata[SID_BITS-1:0];
   assign in_t   = req_tdata[SID_BITS +: TIME_BITS];
   assign in_p   = req_tdata[SID_BITS+TIME_BITS +: PAYLOAD_BITS];

   // Wrap out-of-range ids; the id is below twice NUM_STREAMS, so one subtract does it
   always_comb begin
      if (32'(in_sid) >= NUM_STREAMS) begin
         in_row = SW'(32'(in_sid) - NUM_STREAMS);
      end else begin
         in_row = SW'(in_sid);
      end
   end

   // Stream buffer rows
   row_ctl_type             ctl_w  [NUM_STREAMS];
   row_stat_type            stat_w [NUM_STREAMS];
   logic [TIME_BITS-1:0]    head_t [NUM_STREAMS];
   logic [PAYLOAD_BITS-1:0] head_p [NUM_STREAMS];

   logic          accept;
   logic          ins_go;
   logic          pop_go;
   logic [SW-1:0] sel_ff, sel_in;

   for (genvar s = 0; s < NUM_STREAMS; s++) begin : g_row
      assign ctl_w[s].ins = ins_go && (in_row == SW'(s));
      assign ctl_w[s].pop = pop_go && (sel_ff == SW'(s));
      mstsync_row #(.BUF_DEPTH(BUF_DEPTH), .TIME_BITS(TIME_BITS)) u_row (
         .clock(clock), .reset(reset), .ctl(ctl_w[s]), .new_t(in_t), .new_p(in_p),
         .stat(stat_w[s]), .head_t(head_t[s]), .head_p(head_p[s])
      );
   end

   // Count non-empty buffers
   logic [CNT_BITS-1:0] nonempty;
   always_comb begin
      nonempty = '0;
      for (int s = 0; s < NUM_STREAMS; s++) begin
         nonempty = nonempty + CNT_BITS'(stat_w[s].head_valid);
      end
   end

   // Configuration register
   logic [ACTIVE_BITS-1:0] active_ff;
   logic [ACTIVE_BITS-1:0] need;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_wen) begin
         active_ff <= csr_wdata;
      end
   end

   // Zero active streams acts as one
   assign need = (active_ff == '0) ? ACTIVE_BITS'(1) : active_ff;

   logic release_ok;
   assign release_ok = (32'(nonempty) >= 32'(need));

   // Sync time and the round minimum
   logic [TIME_BITS-1:0] sync_ff, sync_in;
   logic [TIME_BITS-1:0] min_ff, min_in;

   // Pending result: held until we know whether another follows it
   logic                    hold_v_ff, hold_v_in;
   logic [SID_BITS-1:0]     hold_sid_ff, hold_sid_in;
   logic [TIME_BITS-1:0]    hold_t_ff, hold_t_in;
   logic [PAYLOAD_BITS-1:0] hold_p_ff, hold_p_in;
   logic [KIND_BITS-1:0]    hold_k_ff, hold_k_in;

   // Output register
   logic                    out_v_ff, out_v_in;
   logic [SID_BITS-1:0]     out_sid_ff, out_sid_in;
   logic [TIME_BITS-1:0]    out_t_ff, out_t_in;
   logic [PAYLOAD_BITS-1:0] out_p_ff, out_p_in;
   logic [KIND_BITS-1:0]    out_k_ff, out_k_in;
   logic                    out_l_ff, out_l_in;

   logic out_free;
   assign out_free   = !out_v_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   logic late, full_hit, head_hit, sel_last;
   assign late     = (in_t <= sync_ff);
   assign full_hit = stat_w[in_row].full;
   assign head_hit = stat_w[sel_ff].head_valid && (head_t[sel_ff] == min_ff);
   assign sel_last = (sel_ff == SW'(NUM_STREAMS - 1));

   always_comb begin
      state_in    = state_ff;
      sel_in      = sel_ff;
      sync_in     = sync_ff;
      min_in      = min_ff;
      hold_v_in   = hold_v_ff;
      hold_sid_in = hold_sid_ff;
      hold_t_in   = hold_t_ff;
      hold_p_in   = hold_p_ff;
      hold_k_in   = hold_k_ff;
      out_v_in    = out_v_ff && !rsp_tready;
      out_sid_in  = out_sid_ff;
      out_t_in    = out_t_ff;
      out_p_in    = out_p_ff;
      out_k_in    = out_k_ff;
      out_l_in    = out_l_ff;
      ins_go      = 1'b0;
      pop_go      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (late || full_hit) begin
                  // Late or dropped: a single result, no release round
                  hold_v_in   = 1'b1;
                  hold_sid_in = in_sid;
                  hold_t_in   = in_t;
                  hold_p_in   = in_p;
                  hold_k_in   = late ? KIND_LATE : KIND_DROP;
                  state_in    = ST_FINISH;
               end else begin
                  ins_go   = 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (release_ok) begin
               min_in   = '1;
               sel_in   = '0;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            // Walk the heads, one stream a cycle, ignoring empty buffers for the minimum
            if (stat_w[sel_ff].head_valid && (head_t[sel_ff] < min_ff)) begin
               min_in = head_t[sel_ff];
            end
            if (sel_last) begin
               sync_in  = min_in;
               sel_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               sel_in = sel_ff + SW'(1);
            end
         end
         ST_DRAIN: begin
            if (head_hit) begin
               if (!hold_v_ff || out_free) begin
                  if (hold_v_ff) begin
                     out_v_in   = 1'b1;
                     out_sid_in = hold_sid_ff;
                     out_t_in   = hold_t_ff;
                     out_p_in   = hold_p_ff;
                     out_k_in   = hold_k_ff;
                     out_l_in   = 1'b0;
                  end
                  hold_v_in   = 1'b1;
                  hold_sid_in = SID_BITS'(sel_ff);
                  hold_t_in   = head_t[sel_ff];
                  hold_p_in   = head_p[sel_ff];
                  hold_k_in   = KIND_SYNC;
                  pop_go      = 1'b1;
               end
            end else if (sel_last) begin
               state_in = ST_CHECK;
            end else begin
               sel_in = sel_ff + SW'(1);
            end
         end
         ST_FINISH: begin
            // Flush the pending result marked as last
            if (!hold_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_v_in   = 1'b1;
               out_sid_in = hold_sid_ff;
               out_t_in   = hold_t_ff;
               out_p_in   = hold_p_ff;
               out_k_in   = hold_k_ff;
               out_l_in   = 1'b1;
               hold_v_in  = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sel_ff    <= '0;
         sync_ff   <= '0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sel_ff    <= sel_in;
         sync_ff   <= sync_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
      min_ff      <= min_in;
      hold_sid_ff <= hold_sid_in;
      hold_t_ff   <= hold_t_in;
      hold_p_ff   <= hold_p_in;
      hold_k_ff   <= hold_k_in;
      out_sid_ff  <= out_sid_in;
      out_t_ff    <= out_t_in;
      out_p_ff    <= out_p_in;
      out_k_ff    <= out_k_in;
      out_l_ff    <= out_l_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = DATA_BITS'({out_p_ff, out_t_ff, out_sid_ff});
   assign rsp_tuser  = out_k_ff;
   assign rsp_tlast  = out_l_ff;

endmodule
